[rtl/ibs_pkg.sv]
// ----------------------------------------------------------------------------
// ibs_pkg
// Shared types and constants of the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package ibs_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;
  localparam logic [15:0] DELAY_RESET = 16'd100;

  localparam logic [2:0] OP_START  = 3'd0;
  localparam logic [2:0] OP_STOP   = 3'd1;
  localparam logic [2:0] OP_WRITE  = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_RSTART = 3'd4;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic       sda_in;
    logic [7:0] tx_byte;
    logic [2:0] operation;
    logic       cmd_valid;
  } item_t;

  typedef struct packed {
    logic       ack_bit;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_level;
    logic       scl_level;
  } res_t;

endpackage

[rtl/i2c_master_bit_sequencer_core.sv]
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// Tick-driven I2C master pin sequencer with a queued front end.
// ----------------------------------------------------------------------------
// Path: a result passes through the input queue and then the output
// register before it appears on m_tdata.
// Throughput: one item per cycle while m_tready does not stall the output,
// set by the combinational step logic.
// Reset: synchronous rst empties the queue, drops m_tvalid, sets the pins
// high and driven, ack to one and delay_ticks to 100.
module i2c_master_bit_sequencer_core #(
  parameter int QUEUE_DEPTH = ibs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // tx_byte[7:0], sda_in[8], zero pad
  input  logic [3:0]  s_tuser,  // cmd_valid[0], operation[3:1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // scl_level, sda_level, sda_drive, busy_res,
                                // done_res, rx_byte[12:5], ack_bit[13], pad
);

  logic           q_valid;
  logic           q_ready;
  ibs_pkg::item_t q_item;

  ibs_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  ibs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

[rtl/ibs_front.sv]
// ----------------------------------------------------------------------------
// ibs_front
// Accepts tick items from the input stream and queues them for the back end.
// ----------------------------------------------------------------------------
module ibs_front #(
  parameter int QUEUE_DEPTH = ibs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [15:0]   s_tdata,
  input  logic [3:0]    s_tuser,
  output logic          q_valid,
  input  logic          q_ready,
  output ibs_pkg::item_t q_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ibs_pkg::item_t          mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        rd_ptr;
  logic [CNT_W-1:0]        count;
  logic                    push;
  logic                    pop;
  ibs_pkg::item_t          in_item;

  assign in_item.cmd_valid = s_tuser[0];
  assign in_item.operation = s_tuser[3:1];
  assign in_item.tx_byte   = s_tdata[7:0];
  assign in_item.sda_in    = s_tdata[8];

  assign s_tready = (count != CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = mem[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/ibs_back.sv]
// ----------------------------------------------------------------------------
// ibs_back
// Plays out I2C pin steps one tick per item and registers each result.
// ----------------------------------------------------------------------------
module ibs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic [15:0]    cfg_wr_data,
  input  logic           q_valid,
  output logic           q_ready,
  input  ibs_pkg::item_t q_item,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [15:0]    m_tdata
);

  logic [15:0] delay_ticks;
  logic [2:0]  active, active_next;
  logic [3:0]  phase, phase_next;
  logic [3:0]  bitc, bitc_next;
  logic [15:0] dcnt, dcnt_next;
  logic [7:0]  shreg, shreg_next;
  logic        scl, scl_next;
  logic        sda, sda_next;
  logic        drv, drv_next;
  logic        ack, ack_next;
  logic [7:0]  rx, rx_next;
  logic        done;
  logic        proc;
  ibs_pkg::res_t res;

  logic        step_en;
  logic [2:0]  step_op;
  logic [3:0]  step_ph;
  logic [3:0]  step_bc;
  logic [7:0]  sh_src;
  logic [3:0]  ph_a;
  logic [3:0]  bc_a;
  logic        cont;
  logic [2:0]  cur_op;
  logic [15:0] load_val;

  assign q_ready = !m_tvalid || m_tready;
  assign proc    = q_valid && q_ready;
  assign cur_op  = active - 3'd1;
  assign load_val = (delay_ticks == '0) ? '0 : delay_ticks - 16'd1;

  always_comb begin
    active_next = active;
    phase_next  = phase;
    bitc_next   = bitc;
    dcnt_next   = dcnt;
    shreg_next  = shreg;
    scl_next    = scl;
    sda_next    = sda;
    drv_next    = drv;
    ack_next    = ack;
    rx_next     = rx;
    done        = 1'b0;
    step_en     = 1'b0;
    step_op     = cur_op;
    step_ph     = '0;
    step_bc     = '0;
    sh_src      = shreg;
    ph_a        = phase + 4'd1;
    bc_a        = bitc;
    cont        = 1'b0;

    if (cur_op == ibs_pkg::OP_WRITE || cur_op == ibs_pkg::OP_READ) begin
      if (bitc < ibs_pkg::BITS_PER_BYTE) begin
        cont = 1'b1;
        if (ph_a >= 4'd3) begin
          ph_a = '0;
          bc_a = bitc + 4'd1;
        end
      end else begin
        cont = (ph_a < 4'd4);
      end
    end else if (cur_op == ibs_pkg::OP_START) begin
      cont = (ph_a < 4'd2);
    end else if (cur_op == ibs_pkg::OP_STOP) begin
      cont = (ph_a < 4'd3);
    end else begin
      cont = (ph_a < 4'd4);
    end

    if (active != '0) begin
      if (dcnt != '0) begin
        dcnt_next = dcnt - 16'd1;
      end else if (cont) begin
        phase_next = ph_a;
        bitc_next  = bc_a;
        step_en    = 1'b1;
        step_ph    = ph_a;
        step_bc    = bc_a;
      end else begin
        active_next = '0;
        phase_next  = '0;
        bitc_next   = '0;
        done        = 1'b1;
      end
    end else if (q_item.cmd_valid && q_item.operation <= ibs_pkg::OP_RSTART) begin
      active_next = q_item.operation + 3'd1;
      phase_next  = '0;
      bitc_next   = '0;
      step_en     = 1'b1;
      step_op     = q_item.operation;
      if (q_item.operation == ibs_pkg::OP_WRITE) begin
        sh_src     = q_item.tx_byte;
        shreg_next = q_item.tx_byte;
      end
    end

    if (step_en) begin
      dcnt_next = load_val;
      case (step_op)
        ibs_pkg::OP_START: begin
          if (step_ph == 4'd0) begin
            sda_next = 1'b0;
            drv_next = 1'b1;
          end else begin
            scl_next = 1'b0;
          end
        end
        ibs_pkg::OP_STOP: begin
          if (step_ph == 4'd0) begin
            sda_next = 1'b0;
            drv_next = 1'b1;
          end else if (step_ph == 4'd1) begin
            scl_next = 1'b1;
          end else begin
            sda_next = 1'b1;
          end
        end
        ibs_pkg::OP_RSTART: begin
          if (step_ph == 4'd0) begin
            sda_next = 1'b1;
            drv_next = 1'b1;
          end else if (step_ph == 4'd1) begin
            scl_next = 1'b1;
          end else if (step_ph == 4'd2) begin
            sda_next = 1'b0;
          end else begin
            scl_next = 1'b0;
          end
        end
        ibs_pkg::OP_WRITE: begin
          if (step_bc < ibs_pkg::BITS_PER_BYTE) begin
            if (step_ph == 4'd0) begin
              sda_next = sh_src[3'd7 - step_bc[2:0]];
              drv_next = 1'b1;
            end else if (step_ph == 4'd1) begin
              scl_next = 1'b1;
            end else begin
              scl_next = 1'b0;
            end
          end else begin
            if (step_ph == 4'd0) begin
              drv_next = 1'b0;
            end else if (step_ph == 4'd1) begin
              scl_next = 1'b1;
            end else if (step_ph == 4'd2) begin
              ack_next = q_item.sda_in;
              scl_next = 1'b0;
            end else begin
              drv_next = 1'b1;
            end
          end
        end
        default: begin
          if (step_bc < ibs_pkg::BITS_PER_BYTE) begin
            if (step_ph == 4'd0) begin
              if (step_bc == 4'd0) begin
                drv_next = 1'b0;
              end
            end else if (step_ph == 4'd1) begin
              scl_next = 1'b1;
            end else begin
              shreg_next = {sh_src[6:0], q_item.sda_in};
              scl_next   = 1'b0;
              if (step_bc == 4'd7) begin
                rx_next = {sh_src[6:0], q_item.sda_in};
              end
            end
          end else begin
            if (step_ph == 4'd0) begin
              drv_next = 1'b1;
            end else if (step_ph == 4'd1) begin
              sda_next = 1'b0;
            end else if (step_ph == 4'd2) begin
              scl_next = 1'b1;
            end else begin
              scl_next = 1'b0;
            end
          end
        end
      endcase
    end
  end

  assign res.scl_level = scl_next;
  assign res.sda_level = sda_next;
  assign res.sda_drive = drv_next;
  assign res.busy_res  = (active_next != '0);
  assign res.done_res  = done;
  assign res.rx_byte   = rx_next;
  assign res.ack_bit   = ack_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= ibs_pkg::DELAY_RESET;
      active      <= '0;
      phase       <= '0;
      bitc        <= '0;
      dcnt        <= '0;
      shreg       <= '0;
      scl         <= 1'b1;
      sda         <= 1'b1;
      drv         <= 1'b1;
      ack         <= 1'b1;
      rx          <= '0;
      m_tvalid    <= 1'b0;
      m_tdata     <= '0;
    end else begin
      if (cfg_wr_en) begin
        delay_ticks <= cfg_wr_data;
      end
      if (proc) begin
        active   <= active_next;
        phase    <= phase_next;
        bitc     <= bitc_next;
        dcnt     <= dcnt_next;
        shreg    <= shreg_next;
        scl      <= scl_next;
        sda      <= sda_next;
        drv      <= drv_next;
        ack      <= ack_next;
        rx       <= rx_next;
        m_tdata  <= {2'b00, res};
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[rtl/ibs_checker.sv]
// ----------------------------------------------------------------------------
// ibs_checker
// Port-level checks of the I2C master bit sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module ibs_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[3] && m_tdata[4]))
    else $error("busy and done together");

  a_release_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[3])
    else $error("SDA released while idle");

endmodule

bind i2c_master_bit_sequencer_core ibs_checker u_ibs_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
